/* src/bdeq_pkg.sv */
// ----------------------------------------------------------------------------
// bdeq_pkg
// Types and constants shared by the debounced button and key queue block.
// ----------------------------------------------------------------------------
package bdeq_pkg;

    localparam int QUEUE_DEPTH = 8;

    // Only power-of-two depths up to 16 use the whole ring; otherwise entry 0.
    localparam int RING_MASK =
        (((QUEUE_DEPTH & (QUEUE_DEPTH - 1)) == 0) && (QUEUE_DEPTH <= 16)) ?
        (QUEUE_DEPTH - 1) : 0;
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam int KEY_W   = 8;
    localparam int COUNT_W = 8;
    localparam int CODE_W  = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_CODE       = 1'd1;

    localparam logic [COUNT_W-1:0] DEBOUNCE_COUNT_RESET = 8'd3;
    localparam logic [KEY_W-1:0]   KEY_CODE_RESET       = 8'd120;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [CODE_W-1:0] CODE_IDLE        = 3'd0;
    localparam logic [CODE_W-1:0] CODE_PRESS_DEB   = 3'd1;
    localparam logic [CODE_W-1:0] CODE_HELD        = 3'd2;
    localparam logic [CODE_W-1:0] CODE_RELEASE_DEB = 3'd3;
    localparam logic [CODE_W-1:0] CODE_STORE       = 3'd4;

    typedef enum logic [4:0] {
        PH_IDLE        = 5'b00001,
        PH_PRESS_DEB   = 5'b00010,
        PH_HELD        = 5'b00100,
        PH_RELEASE_DEB = 5'b01000,
        PH_STORE       = 5'b10000
    } phase_t;

    typedef struct packed {
        logic command;
        logic pin_level;
    } in_word_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key_out;
        logic [CODE_W-1:0] debounce_phase;
    } out_word_t;

endpackage

/* src/button_debounce_event_queue.sv */
// ----------------------------------------------------------------------------
// button_debounce_event_queue
// Debounced active-low push button that queues a key code per press/release.
// ----------------------------------------------------------------------------
// Usage: each input word is either a scan tick (command 0) carrying the sampled
// pin level, or a read (command 1) that pops one queued key code. Every input
// word yields exactly one output word with the popped key (zero for ticks and
// empty reads) and the debounce phase after the word.
// The configuration channel writes the debounce count (index 0) or the key
// code (index 1); it is always ready.
// Output words are registered. One word is accepted per cycle while in_ready
// is high; the phase, counter and ring update in the cycle of acceptance.
// The output register is backed by a one-word skid register, so a word is
// still accepted in the cycle the receiver first stalls; in_ready drops only
// while both are full and returns once the receiver takes a word.
// Reset clears the phase to idle, the counter and both ring pointers to zero,
// every ring entry to zero, and restores the configuration reset values.
// ----------------------------------------------------------------------------
module button_debounce_event_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  bdeq_pkg::in_word_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output bdeq_pkg::out_word_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bdeq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bdeq_pkg::COUNT_W-1:0]        cfg_data
);
    import bdeq_pkg::*;

    localparam logic [IDX_W-1:0] MASK = RING_MASK[IDX_W-1:0];

    logic [COUNT_W-1:0] debounce_count_reg;
    logic [KEY_W-1:0]   key_code_reg;

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] counter_reg, counter_next;
    logic [IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [KEY_W-1:0]   ring_reg [QUEUE_DEPTH];

    logic               ring_we;
    logic               ring_clr;
    logic [KEY_W-1:0]   rd_value;
    logic [KEY_W-1:0]   key_result;
    logic [CODE_W-1:0]  phase_code;
    out_word_t          result;

    logic               out_valid_reg;
    out_word_t          out_word_reg;
    logic               skid_valid_reg;
    out_word_t          skid_word_reg;

    logic               in_fire;
    logic               out_free;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    assign rd_value = ring_reg[rd_idx_reg & MASK];

    always_comb
    begin
        phase_next   = phase_reg;
        counter_next = counter_reg;
        wr_idx_next  = wr_idx_reg;
        rd_idx_next  = rd_idx_reg;
        ring_we      = 1'b0;
        ring_clr     = 1'b0;
        key_result   = '0;
        if (in_data.command == CMD_READ)
        begin
            key_result = rd_value;
            if (rd_value != '0)
            begin
                ring_clr    = 1'b1;
                rd_idx_next = (rd_idx_reg + 1'b1) & MASK;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (!in_data.pin_level)
                    begin
                        counter_next = debounce_count_reg;
                        phase_next   = PH_PRESS_DEB;
                    end
                end
                PH_PRESS_DEB:
                begin
                    if (in_data.pin_level)
                        phase_next = PH_IDLE;
                    else if (counter_reg != '0)
                        counter_next = counter_reg - 1'b1;
                    else
                        phase_next = PH_HELD;
                end
                PH_HELD:
                begin
                    if (in_data.pin_level)
                    begin
                        counter_next = debounce_count_reg;
                        phase_next   = PH_RELEASE_DEB;
                    end
                end
                PH_RELEASE_DEB:
                begin
                    if (!in_data.pin_level)
                        phase_next = PH_IDLE;
                    else if (counter_reg != '0)
                        counter_next = counter_reg - 1'b1;
                    else
                        phase_next = PH_STORE;
                end
                PH_STORE:
                begin
                    ring_we     = 1'b1;
                    wr_idx_next = (wr_idx_reg + 1'b1) & MASK;
                    phase_next  = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (phase_next)
            PH_IDLE:        phase_code = CODE_IDLE;
            PH_PRESS_DEB:   phase_code = CODE_PRESS_DEB;
            PH_HELD:        phase_code = CODE_HELD;
            PH_RELEASE_DEB: phase_code = CODE_RELEASE_DEB;
            PH_STORE:       phase_code = CODE_STORE;
            default:        phase_code = CODE_IDLE;
        endcase
    end

    assign result.key_out        = key_result;
    assign result.debounce_phase = phase_code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_count_reg <= DEBOUNCE_COUNT_RESET;
            key_code_reg       <= KEY_CODE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE_COUNT: debounce_count_reg <= cfg_data;
                CFG_KEY_CODE:       key_code_reg       <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            counter_reg <= '0;
            wr_idx_reg  <= '0;
            rd_idx_reg  <= '0;
            for (int i = 0; i < QUEUE_DEPTH; i++)
                ring_reg[i] <= '0;
        end
        else if (in_fire)
        begin
            phase_reg   <= phase_next;
            counter_reg <= counter_next;
            wr_idx_reg  <= wr_idx_next;
            rd_idx_reg  <= rd_idx_next;
            // A write and a clear never happen together: one is a tick, one a read.
            if (ring_we)
                ring_reg[wr_idx_reg & MASK] <= key_code_reg;
            else if (ring_clr)
                ring_reg[rd_idx_reg & MASK] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_word_reg <= skid_word_reg;
            else if (in_fire)
                out_word_reg <= result;
        end
        else if (in_fire)
        begin
            skid_word_reg <= result;
        end
    end

    // The skid register is only ever filled behind a held output word.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without an output word");

    // A scan tick never pops a key.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.command == CMD_TICK) |-> (result.key_out == '0))
        else $error("scan tick produced a key");

    // The store phase always falls back to idle on the next tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.command == CMD_TICK && phase_reg == PH_STORE)
        |=> (phase_reg == PH_IDLE))
        else $error("store phase did not return to idle");

    // A read that returns a key advances the read pointer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.command == CMD_READ && rd_value != '0)
        |=> (rd_idx_reg == (($past(rd_idx_reg) + 1'b1) & MASK)))
        else $error("read pointer did not advance after a pop");

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the debounced button with its key-code ring.
// A directed table walks the phase machine, the empty and zero-code reads and
// the counter load; random press, bounce, noise and read sequences follow
// under several debounce and key-code settings. Each output word is compared
// with its row's fixed expectation or a cycle-free model of the machine and ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    import bdeq_pkg::*;

    localparam int          CLK_PERIOD    = 20;
    localparam int          RESET_CYCLES  = 12;
    localparam int unsigned CYCLE_LIMIT   = 400_000;
    localparam int          SETTLE_CYCLES = 10;
    localparam int          LONG_HOLD     = 60;
    localparam int          RAND_PHASES   = 8;
    localparam int          BIG_PHASE     = 5;
    localparam int unsigned PHASE_WORDS   = 20;
    localparam int          SCRIPT_LEN    = 30;

    localparam logic PIN_PRESSED  = 1'b0;
    localparam logic PIN_RELEASED = 1'b1;

    localparam logic [KEY_W-1:0] NO_KEY = '0;

    typedef enum bit {ROW_WORD, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic                   cmd;
        logic                   pin;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [COUNT_W-1:0]     reg_val;
        bit                     typed;
        logic [KEY_W-1:0]       key;
        logic [CODE_W-1:0]      ph;
    } script_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_word_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_word_t              out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [COUNT_W-1:0]     cfg_data;

    // Model of the block: phase machine, settle counter, ring and settings.
    logic [CODE_W-1:0]      ph_now      = CODE_IDLE;
    logic [COUNT_W-1:0]     settle_left = '0;
    logic [KEY_W-1:0]       key_slots [QUEUE_DEPTH];
    int unsigned            put_ptr     = 0;
    int unsigned            take_ptr    = 0;
    logic [COUNT_W-1:0]     cur_debounce = DEBOUNCE_COUNT_RESET;
    logic [KEY_W-1:0]       cur_key      = KEY_CODE_RESET;

    out_word_t              key_phase_fifo [$];
    script_row_t            script [SCRIPT_LEN];

    int unsigned            words_sent   = 0;
    int unsigned            mismatches   = 0;
    int unsigned            cycle_count  = 0;
    bit                     tx_gaps      = 1'b1;
    bit                     rx_gaps      = 1'b1;
    bit                     hold_off_req = 1'b0;

    button_debounce_event_queue u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // One step of the button machine or one pop from the ring.
    function automatic out_word_t button_step(input in_word_t w);
        out_word_t   r;
        int unsigned slot;
        r.key_out = NO_KEY;
        if (w.command == CMD_READ)
        begin
            slot = take_ptr & RING_MASK;
            r.key_out = key_slots[slot];
            if (key_slots[slot] != '0)
            begin
                key_slots[slot] = '0;
                take_ptr = (take_ptr + 1) & RING_MASK;
            end
        end
        else
        begin
            case (ph_now)
                CODE_IDLE:
                begin
                    if (w.pin_level == PIN_PRESSED)
                    begin
                        settle_left = cur_debounce;
                        ph_now = CODE_PRESS_DEB;
                    end
                end
                CODE_PRESS_DEB:
                begin
                    if (w.pin_level == PIN_PRESSED)
                    begin
                        if (settle_left != '0) settle_left = settle_left - 1'b1;
                        else ph_now = CODE_HELD;
                    end
                    else
                    begin
                        ph_now = CODE_IDLE;
                    end
                end
                CODE_HELD:
                begin
                    if (w.pin_level == PIN_RELEASED)
                    begin
                        settle_left = cur_debounce;
                        ph_now = CODE_RELEASE_DEB;
                    end
                end
                CODE_RELEASE_DEB:
                begin
                    if (w.pin_level == PIN_RELEASED)
                    begin
                        if (settle_left != '0) settle_left = settle_left - 1'b1;
                        else ph_now = CODE_STORE;
                    end
                    else
                    begin
                        ph_now = CODE_IDLE;
                    end
                end
                CODE_STORE:
                begin
                    // The ring has no full check, so an older entry is overwritten.
                    key_slots[put_ptr & RING_MASK] = cur_key;
                    put_ptr = (put_ptr + 1) & RING_MASK;
                    ph_now = CODE_IDLE;
                end
                default:
                begin
                    ph_now = CODE_IDLE;
                end
            endcase
        end
        r.debounce_phase = ph_now;
        return r;
    endfunction

    function automatic script_row_t row_checked(input logic cmd, input logic pin,
                                                input logic [KEY_W-1:0] key,
                                                input logic [CODE_W-1:0] ph);
        script_row_t row;
        row = '0;
        row.kind  = ROW_WORD;
        row.cmd   = cmd;
        row.pin   = pin;
        row.typed = 1'b1;
        row.key   = key;
        row.ph    = ph;
        return row;
    endfunction

    function automatic script_row_t row_open(input logic cmd, input logic pin);
        script_row_t row;
        row = '0;
        row.kind = ROW_WORD;
        row.cmd  = cmd;
        row.pin  = pin;
        return row;
    endfunction

    function automatic script_row_t row_write(input logic [CFG_IDX_W-1:0] idx,
                                              input logic [COUNT_W-1:0] val);
        script_row_t row;
        row = '0;
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    // Offers one word and waits for it to be taken. The fixed expectation
    // replaces the model's answer on directed rows, but the model still steps.
    task automatic send_word(input logic cmd, input logic pin, input bit typed,
                             input out_word_t want);
        in_word_t  w;
        out_word_t r;
        int        gap;
        cfg_valid <= 1'b0;
        w.command   = cmd;
        w.pin_level = pin;
        if (tx_gaps && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
        r = button_step(w);
        if (typed) r = want;
        key_phase_fifo.push_back(r);
        words_sent++;
    endtask

    task automatic send_plain(input logic cmd, input logic pin);
        send_word(cmd, pin, 1'b0, '0);
    endtask

    task automatic drain_queue();
        in_valid <= 1'b0;
        while (key_phase_fifo.size() != 0) @(posedge clk);
    endtask

    // The valid stays up after the write; the next word or write takes it over.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [COUNT_W-1:0] val);
        drain_queue();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_DEBOUNCE_COUNT) cur_debounce = val;
        else cur_key = val;
    endtask

    task automatic tick_with_reads(input logic pin);
        if ($urandom_range(0, 7) == 0) send_plain(CMD_READ, 1'($urandom_range(0, 1)));
        send_plain(CMD_TICK, pin);
    endtask

    // A clean press and release, long enough to settle both, then the store tick.
    task automatic press_release();
        int unsigned lows;
        int unsigned highs;
        lows  = cur_debounce + 2 + $urandom_range(0, 2);
        highs = cur_debounce + 3 + $urandom_range(0, 2);
        repeat (lows) tick_with_reads(PIN_PRESSED);
        repeat (highs) tick_with_reads(PIN_RELEASED);
    endtask

    initial
    begin
        int          stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left != 0)
            begin
                stall_left--;
                if (stall_left == 0) out_ready <= 1'b1;
            end
            else if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left = LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (rx_gaps && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 19);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (key_phase_fifo.size() == 0)
            begin
                $error("output word with nothing pending: key_out=%0d debounce_phase=%0d",
                       out_data.key_out, out_data.debounce_phase);
                mismatches++;
            end
            else
            begin
                want = key_phase_fifo.pop_front();
                if (out_data.key_out !== want.key_out)
                begin
                    $error("key_out: expected %0d, got %0d", want.key_out, out_data.key_out);
                    mismatches++;
                end
                if (out_data.debounce_phase !== want.debounce_phase)
                begin
                    $error("debounce_phase: expected %0d, got %0d",
                           want.debounce_phase, out_data.debounce_phase);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        out_word_t   want;
        int unsigned dc;
        int unsigned kc;
        int unsigned first_word;
        int unsigned pick;
        bit          last;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        key_slots = '{default: '0};

        script = '{
            row_checked(CMD_READ, PIN_PRESSED,  NO_KEY, CODE_IDLE),
            row_checked(CMD_TICK, PIN_RELEASED, NO_KEY, CODE_IDLE),
            row_checked(CMD_TICK, PIN_PRESSED,  NO_KEY, CODE_PRESS_DEB),
            // A read leaves the machine alone whatever the pin says.
            row_checked(CMD_READ, PIN_RELEASED, NO_KEY, CODE_PRESS_DEB),
            row_checked(CMD_TICK, PIN_RELEASED, NO_KEY, CODE_IDLE),
            row_write(CFG_DEBOUNCE_COUNT, 8'd0),
            row_checked(CMD_TICK, PIN_PRESSED,  NO_KEY, CODE_PRESS_DEB),
            row_checked(CMD_TICK, PIN_PRESSED,  NO_KEY, CODE_HELD),
            row_checked(CMD_TICK, PIN_RELEASED, NO_KEY, CODE_RELEASE_DEB),
            row_checked(CMD_TICK, PIN_PRESSED,  NO_KEY, CODE_IDLE),
            row_open(CMD_TICK, PIN_PRESSED),
            row_open(CMD_TICK, PIN_PRESSED),
            row_open(CMD_TICK, PIN_RELEASED),
            row_checked(CMD_TICK, PIN_RELEASED, NO_KEY, CODE_STORE),
            // The store tick ignores the pin.
            row_checked(CMD_TICK, PIN_PRESSED,  NO_KEY, CODE_IDLE),
            row_checked(CMD_READ, PIN_RELEASED, KEY_CODE_RESET, CODE_IDLE),
            row_checked(CMD_READ, PIN_PRESSED,  NO_KEY, CODE_IDLE),
            // A zero key code is stored but reads back as an empty entry.
            row_write(CFG_KEY_CODE, 8'd0),
            row_open(CMD_TICK, PIN_PRESSED),
            row_open(CMD_TICK, PIN_PRESSED),
            row_open(CMD_TICK, PIN_RELEASED),
            row_open(CMD_TICK, PIN_RELEASED),
            row_open(CMD_TICK, PIN_RELEASED),
            row_checked(CMD_READ, PIN_PRESSED,  NO_KEY, CODE_IDLE),
            row_write(CFG_KEY_CODE, 8'd255),
            row_write(CFG_DEBOUNCE_COUNT, 8'd255),
            row_checked(CMD_TICK, PIN_PRESSED,  NO_KEY, CODE_PRESS_DEB),
            // The counter was loaded on entry, so lowering the count now has
            // no effect on this debounce.
            row_write(CFG_DEBOUNCE_COUNT, 8'd0),
            row_checked(CMD_TICK, PIN_PRESSED,  NO_KEY, CODE_PRESS_DEB),
            row_checked(CMD_TICK, PIN_RELEASED, NO_KEY, CODE_IDLE)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].kind == ROW_REG)
            begin
                write_reg(script[i].reg_idx, script[i].reg_val);
            end
            else
            begin
                want.key_out        = script[i].key;
                want.debounce_phase = script[i].ph;
                send_word(script[i].cmd, script[i].pin, script[i].typed, want);
            end
        end

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            if (p == 1) dc = 0;
            else if (p == BIG_PHASE) dc = 255;
            else if ($urandom_range(0, 2) == 0) dc = $urandom_range(4, 12);
            else dc = $urandom_range(0, 3);
            case (p)
                2: kc = 1;
                3: kc = 0;
                4: kc = 255;
                default: kc = $urandom_range(1, 255);
            endcase
            write_reg(CFG_DEBOUNCE_COUNT, dc[COUNT_W-1:0]);
            write_reg(CFG_KEY_CODE, kc[COUNT_W-1:0]);

            last    = (p == RAND_PHASES - 1);
            tx_gaps = !last && p != 1 && $urandom_range(0, 3) != 0;
            rx_gaps = !last && $urandom_range(0, 3) != 0;
            // The sender keeps offering while the receiver holds off, so the
            // block fills up and has to stall its input.
            if (p == 1) hold_off_req = 1'b1;

            if (p == BIG_PHASE)
            begin
                // The longest press debounce runs to the held state; the
                // release then bounces back to idle right away.
                repeat (cur_debounce + 2) tick_with_reads(PIN_PRESSED);
                tick_with_reads(PIN_RELEASED);
                tick_with_reads(PIN_PRESSED);
            end
            else
            begin
                first_word = words_sent;
                while (words_sent - first_word < PHASE_WORDS)
                begin
                    pick = $urandom_range(0, 19);
                    if (pick < 10)
                    begin
                        press_release();
                    end
                    else if (pick < 13)
                    begin
                        // A press that bounces before it settles, or a release that does.
                        if ($urandom_range(0, 1) == 0)
                        begin
                            repeat ($urandom_range(1, cur_debounce + 1))
                                tick_with_reads(PIN_PRESSED);
                            tick_with_reads(PIN_RELEASED);
                        end
                        else
                        begin
                            repeat (cur_debounce + 2) tick_with_reads(PIN_PRESSED);
                            repeat ($urandom_range(1, cur_debounce + 1))
                                tick_with_reads(PIN_RELEASED);
                            tick_with_reads(PIN_PRESSED);
                        end
                    end
                    else if (pick < 16)
                    begin
                        repeat ($urandom_range(1, 6))
                            send_plain(CMD_TICK, 1'($urandom_range(0, 1)));
                    end
                    else
                    begin
                        repeat ($urandom_range(1, 4))
                            send_plain(CMD_READ, 1'($urandom_range(0, 1)));
                    end
                end
            end
        end

        drain_queue();
        cfg_valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
